@@ hw/rtl/mpt_pkg.sv @@
`default_nettype none
package mpt_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 8;
    localparam int MM_PER_PIXEL  = 20;

    localparam int POS_W   = 20;           // Q12.8 output position
    localparam int POSI_W  = 21;           // internal position, frames up to 8191 wide
    localparam int SPAN_W  = 21;
    localparam int ANG_W   = 16;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS + 2;
    localparam int RAD_W   = 2 * SPAN_W;
    localparam int ROOT_W  = SPAN_W;
    localparam int CW      = 32;           // CORDIC x/y datapath
    localparam int ZW      = 25;           // CORDIC angle, 1/65536 degree
    localparam int STEPS   = 16;
    localparam int STEP_W  = 4;
    localparam int PROD_W  = 48;
    localparam int T_W     = 25;
    localparam int OFF_W   = 22;
    localparam int CHK_W   = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int FULL_TURN    = 2 * HALF_TURN;
    localparam longint CORDIC_GAIN = 652032874;

    // floor(v / MM_PER_PIXEL) as (v * RECIP) >> RECIP_SHIFT, exact for v < 2^25
    localparam int RECIP_SHIFT = 30;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + MM_PER_PIXEL - 1) / MM_PER_PIXEL;
    localparam int RECIP_W     = 26;
    localparam int TRIG_SHIFT  = RECIP_SHIFT - FRACTION_BITS;
    localparam int ROUND_HALF  = MM_PER_PIXEL / 2;

    typedef enum logic [1:0] {
        MODE_PIXEL  = 2'd0,
        MODE_ROTATE = 2'd1,
        MODE_SET    = 2'd2,
        MODE_MOVE   = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd4;

    typedef struct packed {
        logic                 start;
        logic                 vectoring;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 25'sd2949120;
            4'd1:    v = 25'sd1740967;
            4'd2:    v = 25'sd919879;
            4'd3:    v = 25'sd466945;
            4'd4:    v = 25'sd234379;
            4'd5:    v = 25'sd117304;
            4'd6:    v = 25'sd58666;
            4'd7:    v = 25'sd29335;
            4'd8:    v = 25'sd14668;
            4'd9:    v = 25'sd7334;
            4'd10:   v = 25'sd3667;
            4'd11:   v = 25'sd1833;
            4'd12:   v = 25'sd917;
            4'd13:   v = 25'sd458;
            4'd14:   v = 25'sd229;
            4'd15:   v = 25'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mpt_if.sv @@
`default_nettype none
interface mpt_cmd_if
    import mpt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [31:0]             pixel_word;
    logic [COORD_BITS-1:0]   row_index;
    logic [COORD_BITS-1:0]   column_index;
    logic                    frame_end;
    logic signed [ANG_W-1:0] angle_value;
    logic signed [15:0]      distance_mm;

    modport source (output valid, mode, pixel_word, row_index, column_index, frame_end,
                    angle_value, distance_mm, input ready);
    modport sink   (input valid, mode, pixel_word, row_index, column_index, frame_end,
                    angle_value, distance_mm, output ready);
endinterface

interface mpt_res_if
    import mpt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        pose_x;
    logic [POS_W-1:0]        pose_y;
    logic signed [ANG_W-1:0] heading;
    logic [SPAN_W-1:0]       marker_span;
    logic                    move_done;
    logic                    degenerate;

    modport source (output valid, pose_x, pose_y, heading, marker_span, move_done,
                    degenerate, input ready);
    modport sink   (input valid, pose_x, pose_y, heading, marker_span, move_done,
                    degenerate, output ready);
endinterface

interface mpt_cfg_if
    import mpt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mpt_cordic.sv @@
`default_nettype none
module mpt_cordic
    import mpt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cordic_req_t    req,
    output logic                done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next, tab;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg, vec_reg, done_reg;
    logic                 plus;

    always_comb
    begin
        xs   = x_reg >>> step_reg;
        ys   = y_reg >>> step_reg;
        tab  = atan_entry(step_reg);
        // vectoring drives y to zero, rotation drives z to zero
        plus = vec_reg ? (y_reg > 0) : z_reg[ZW-1];
        x_next = plus ? x_reg + ys  : x_reg - ys;
        y_next = plus ? y_reg - xs  : y_reg + xs;
        z_next = plus ? z_reg + tab : z_reg - tab;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (step_reg == STEP_W'(STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                vec_reg  <= req.vectoring;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            z_reg <= req.z;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

@@ hw/rtl/mpt_sqrt.sv @@
`default_nettype none
module mpt_sqrt
    import mpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sqrt_req_t   req,
    output logic             done,
    output logic [ROOT_W-1:0] root
);
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [REM_W+1:0]  rem_sh, trial;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

@@ hw/rtl/marker_pose_tracker.sv @@
// Plain pixels: one transfer per cycle while idle, no result.
// Rotate and set heading: the result loads from ST_FIN once the output is free.
// Frame end: two squares, two 21-step roots, 16-step CORDIC vectoring; the roots and
// vectoring are skipped when the markers coincide. Move: 16-step CORDIC rotation,
// two multiply/scale passes, pad, compare. Input is ready again once the result loads.
// rst_n clears pose, heading, span, radius, marker latches and loads default config.
`default_nettype none
module marker_pose_tracker
    import mpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpt_cmd_if.sink   cmd,
    mpt_res_if.source result,
    mpt_cfg_if.sink   cfg
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_ROOT_SPAN, ST_ROOT_RAD, ST_ATAN,
        ST_MV_TRIG, ST_MV_MUL, ST_MV_ABS, ST_MV_SCALE, ST_MV_PAD, ST_MV_CHECK, ST_FIN
    } state_t;

    state_t state_reg;

    logic [7:0]              green_reg, blue_reg;
    logic [12:0]             width_reg, height_reg;
    logic [15:0]             pad_mm_reg;

    logic [COORD_BITS-1:0]   left_x_reg, left_y_reg, right_x_reg, right_y_reg;
    logic [POSI_W-1:0]       pos_x_reg, pos_y_reg;
    logic signed [ANG_W-1:0] heading_reg;
    logic [SPAN_W-1:0]       span_reg, radius_reg;
    logic                    move_done_reg, degen_reg;

    logic [SQ_W-1:0]         sq_reg;
    logic signed [15:0]      mm_reg;
    logic                    flip_reg, axis_reg, neg_reg;
    logic signed [CW-1:0]    cos_reg, sin_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [T_W-1:0]          t_reg;
    logic signed [OFF_W-1:0] offx_reg, offy_reg;
    logic [POS_W-1:0]        pad_px_reg;

    logic                    out_valid_reg;
    logic [POS_W-1:0]        out_x_reg, out_y_reg;
    logic signed [ANG_W-1:0] out_heading_reg;
    logic [SPAN_W-1:0]       out_span_reg;
    logic                    out_move_reg, out_degen_reg;

    cordic_req_t             cordic_req;
    logic                    cordic_done;
    logic signed [CW-1:0]    cordic_x, cordic_y;
    logic signed [ZW-1:0]    cordic_z;
    sqrt_req_t               sqrt_req;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;

    logic                    cmd_xfer, out_free;
    logic                    cordic_launch, sqrt_launch;
    logic                    g_hit, b_hit;
    logic [COORD_BITS-1:0]   lx_new, ly_new, rx_new, ry_new;
    logic signed [DIFF_W-1:0] dx, dy, ady;
    logic [SQ_W-1:0]         sq_sum;
    logic signed [17:0]      rot_sum, rot_wrap;
    logic signed [ANG_W-1:0] trig_h;
    logic                    trig_flip;
    logic signed [ZW:0]      z_mag;
    logic [16:0]             z_round;
    logic signed [ANG_W-1:0] atan_heading;
    logic signed [PROD_W-1:0] prod_abs;
    logic [T_W+RECIP_W-1:0]  scaled;
    logic [OFF_W-1:0]        q_val;
    logic [49:0]             pad_prod;
    logic signed [CHK_W-1:0] nx, ny, lo, hix, hiy;
    logic                    fits;

    mpt_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .done  (cordic_done),
        .x_out (cordic_x),
        .y_out (cordic_y),
        .z_out (cordic_z)
    );

    mpt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        g_hit  = cmd.pixel_word[23:16] >= green_reg;
        b_hit  = cmd.pixel_word[31:24] >= blue_reg;
        lx_new = g_hit ? cmd.row_index    : left_x_reg;
        ly_new = g_hit ? cmd.column_index : left_y_reg;
        rx_new = b_hit ? cmd.row_index    : right_x_reg;
        ry_new = b_hit ? cmd.column_index : right_y_reg;

        dx  = $signed({1'b0, left_x_reg}) - $signed({1'b0, right_x_reg});
        dy  = $signed({1'b0, left_y_reg}) - $signed({1'b0, right_y_reg});
        ady = dy[DIFF_W-1] ? -dy : dy;
        sq_sum = sq_reg + SQ_W'(dy) * SQ_W'(dy);

        cordic_launch = ((state_reg == ST_IDLE) && cmd_xfer && (mode_t'(cmd.mode) == MODE_MOVE))
                        || ((state_reg == ST_ROOT_RAD) && sqrt_done);
        sqrt_launch   = ((state_reg == ST_SQ_Y) && (sq_sum != '0))
                        || ((state_reg == ST_ROOT_SPAN) && sqrt_done);

        // heading wrap into [-180, 180)
        if (mode_t'(cmd.mode) == MODE_ROTATE)
            rot_sum = 18'(heading_reg) + 18'(cmd.angle_value);
        else
            rot_sum = 18'(cmd.angle_value);
        if (rot_sum >= 18'sd23040)
            rot_wrap = rot_sum - 18'(FULL_TURN);
        else if (rot_sum < -18'sd23040)
            rot_wrap = rot_sum + 18'(FULL_TURN);
        else
            rot_wrap = rot_sum;

        // fold heading into [-90, 90] for the rotation pass
        trig_flip = 1'b1;
        if (heading_reg > 16'sd11520)
            trig_h = heading_reg - 16'(HALF_TURN);
        else if (heading_reg < -16'sd11520)
            trig_h = heading_reg + 16'(HALF_TURN);
        else
        begin
            trig_h    = heading_reg;
            trig_flip = 1'b0;
        end

        // 1/65536 degree to 1/128 degree, halves away from zero, negated
        z_mag   = cordic_z[ZW-1] ? -(ZW+1)'(cordic_z) : (ZW+1)'(cordic_z);
        z_round = 17'((z_mag + (ZW+1)'(256)) >>> 9);
        atan_heading = cordic_z[ZW-1] ? 16'(z_round) : -16'(z_round);

        prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        scaled   = t_reg * RECIP_W'(RECIP);
        q_val    = OFF_W'(scaled >> RECIP_SHIFT);
        pad_prod = {pad_mm_reg, 8'b0} * RECIP_W'(RECIP);

        nx  = $signed({3'b0, pos_x_reg}) + CHK_W'(offx_reg);
        ny  = $signed({3'b0, pos_y_reg}) - CHK_W'(offy_reg);
        lo  = $signed({4'b0, pad_px_reg}) + $signed({3'b0, radius_reg});
        hix = $signed({3'b0, width_reg, 8'b0}) - lo;
        hiy = $signed({3'b0, height_reg, 8'b0}) - lo;
        fits = (nx > lo) && (nx < hix) && (ny > lo) && (ny < hiy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= 8'd200;
            blue_reg   <= 8'd200;
            width_reg  <= 13'd800;
            height_reg <= 13'd600;
            pad_mm_reg <= 16'd200;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_GREEN:  green_reg  <= cfg.data[7:0];
                REG_BLUE:   blue_reg   <= cfg.data[7:0];
                REG_WIDTH:  width_reg  <= cfg.data[12:0];
                REG_HEIGHT: height_reg <= cfg.data[12:0];
                REG_PAD:    pad_mm_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            right_x_reg   <= '0;
            right_y_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            span_reg      <= '0;
            radius_reg    <= '0;
            move_done_reg <= 1'b0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cordic_req    <= '0;
            sqrt_req      <= '0;
        end
        else
        begin
            cordic_req.start <= cordic_launch;
            sqrt_req.start   <= sqrt_launch;
            if ((state_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        move_done_reg <= 1'b0;
                        degen_reg     <= 1'b0;
                        case (mode_t'(cmd.mode))
                            MODE_PIXEL:
                            begin
                                left_x_reg  <= lx_new;
                                left_y_reg  <= ly_new;
                                right_x_reg <= rx_new;
                                right_y_reg <= ry_new;
                                if (cmd.frame_end)
                                begin
                                    pos_x_reg <= POSI_W'({{1'b0, lx_new} + {1'b0, rx_new},
                                                          7'b0});
                                    pos_y_reg <= POSI_W'({{1'b0, ly_new} + {1'b0, ry_new},
                                                          7'b0});
                                    state_reg <= ST_SQ_X;
                                end
                            end
                            MODE_ROTATE, MODE_SET:
                            begin
                                heading_reg <= ANG_W'(rot_wrap);
                                state_reg   <= ST_FIN;
                            end
                            MODE_MOVE:
                            begin
                                mm_reg               <= cmd.distance_mm;
                                flip_reg             <= trig_flip;
                                cordic_req.vectoring <= 1'b0;
                                cordic_req.x         <= CW'(CORDIC_GAIN);
                                cordic_req.y         <= '0;
                                cordic_req.z         <= ZW'({trig_h, 9'b0});
                                axis_reg             <= 1'b0;
                                state_reg            <= ST_MV_TRIG;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SQ_X:
                begin
                    sq_reg    <= SQ_W'(dx) * SQ_W'(dx);
                    state_reg <= ST_SQ_Y;
                end
                ST_SQ_Y:
                begin
                    sq_reg <= sq_sum;
                    if (sq_sum == '0)
                    begin
                        degen_reg   <= 1'b1;
                        heading_reg <= '0;
                        span_reg    <= '0;
                        radius_reg  <= '0;
                        // a locate ends the frame: markers start over
                        left_x_reg  <= '0;
                        left_y_reg  <= '0;
                        right_x_reg <= '0;
                        right_y_reg <= '0;
                        state_reg   <= ST_FIN;
                    end
                    else
                    begin
                        sqrt_req.radicand <= RAD_W'({sq_sum, 16'b0});
                        state_reg         <= ST_ROOT_SPAN;
                    end
                end
                ST_ROOT_SPAN:
                begin
                    if (sqrt_done)
                    begin
                        span_reg          <= sqrt_root;
                        sqrt_req.radicand <= RAD_W'({sq_reg, 15'b0});
                        state_reg         <= ST_ROOT_RAD;
                    end
                end
                ST_ROOT_RAD:
                begin
                    if (sqrt_done)
                    begin
                        radius_reg           <= sqrt_root;
                        cordic_req.vectoring <= 1'b1;
                        cordic_req.x         <= $signed({3'b0, ady, 16'b0});
                        cordic_req.y         <= $signed({{3{dx[DIFF_W-1]}}, dx, 16'b0});
                        cordic_req.z         <= '0;
                        // markers are no longer needed once the vectoring pass is loaded
                        left_x_reg           <= '0;
                        left_y_reg           <= '0;
                        right_x_reg          <= '0;
                        right_y_reg          <= '0;
                        state_reg            <= ST_ATAN;
                    end
                end
                ST_ATAN:
                begin
                    if (cordic_done)
                    begin
                        heading_reg <= atan_heading;
                        state_reg   <= ST_FIN;
                    end
                end
                ST_MV_TRIG:
                begin
                    if (cordic_done)
                    begin
                        cos_reg   <= flip_reg ? -cordic_x : cordic_x;
                        sin_reg   <= flip_reg ? -cordic_y : cordic_y;
                        state_reg <= ST_MV_MUL;
                    end
                end
                ST_MV_MUL:
                begin
                    prod_reg  <= PROD_W'(mm_reg) * PROD_W'(axis_reg ? sin_reg : cos_reg);
                    state_reg <= ST_MV_ABS;
                end
                ST_MV_ABS:
                begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    t_reg     <= T_W'(prod_abs >>> TRIG_SHIFT) + T_W'(ROUND_HALF);
                    state_reg <= ST_MV_SCALE;
                end
                ST_MV_SCALE:
                begin
                    if (axis_reg)
                    begin
                        offy_reg  <= neg_reg ? -$signed(q_val) : $signed(q_val);
                        state_reg <= ST_MV_PAD;
                    end
                    else
                    begin
                        offx_reg  <= neg_reg ? -$signed(q_val) : $signed(q_val);
                        axis_reg  <= 1'b1;
                        state_reg <= ST_MV_MUL;
                    end
                end
                ST_MV_PAD:
                begin
                    pad_px_reg <= POS_W'(pad_prod >> RECIP_SHIFT);
                    state_reg  <= ST_MV_CHECK;
                end
                ST_MV_CHECK:
                begin
                    if (fits)
                    begin
                        pos_x_reg     <= POSI_W'(nx);
                        pos_y_reg     <= POSI_W'(ny);
                        move_done_reg <= 1'b1;
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_x_reg       <= pos_x_reg[POS_W-1:0];
                        out_y_reg       <= pos_y_reg[POS_W-1:0];
                        out_heading_reg <= heading_reg;
                        out_span_reg    <= span_reg;
                        out_move_reg    <= move_done_reg;
                        out_degen_reg   <= degen_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pose_x      = out_x_reg;
    assign result.pose_y      = out_y_reg;
    assign result.heading     = out_heading_reg;
    assign result.marker_span = out_span_reg;
    assign result.move_done   = out_move_reg;
    assign result.degenerate  = out_degen_reg;

    a_move_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.move_done && result.degenerate))
        else $error("move_done and degenerate both set");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.heading >= -16'sd23040))
        else $error("heading below -180 degrees");

    a_plain_pixel_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (mode_t'(cmd.mode) == MODE_PIXEL) && !cmd.frame_end
         && !result.valid) |=> !result.valid)
        else $error("result after a plain pixel");

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!cordic_done && !sqrt_done))
        else $error("arithmetic unit finished while idle");
endmodule
`default_nettype wire

@@ tb/sv/marker_pose_tracker_checker.sv @@
module marker_pose_tracker_checker
    import mpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mpt_cmd_if.sink   cmd,
    mpt_res_if.sink   result,
    mpt_cfg_if.sink   cfg,
    output int        fail_count,
    output int        pending,
    output int        pose_count
);

    typedef struct packed {
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [ANG_W-1:0] hd;
        logic [SPAN_W-1:0]       span;
        logic                    done;
        logic                    degen;
    } pose_t;

    pose_t pose_q[$];

    logic [7:0]  thr_green, thr_blue;
    logic [12:0] ext_x, ext_y;
    logic [15:0] pad_set;
    logic [11:0] lx, ly, rx, ry;
    longint      cur_x, cur_y, radius;
    int          cur_hd;
    logic [SPAN_W-1:0] cur_span;

    longint atan_lut[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic int wrap_deg(longint h);
        longint m;
        m = (h + HALF_TURN) % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        return int'(m - HALF_TURN);
    endfunction

    // floor(sqrt(v * 4^extra))
    function automatic longint isqrt(longint unsigned v, int extra);
        longint unsigned root, rem, pair, trial;
        root = 0;
        rem = 0;
        for (int i = 31 + extra; i >= 0; i--) begin
            pair = (i >= extra) ? ((v >> (2 * (i - extra))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return longint'(root);
    endfunction

    function automatic longint clip_span(longint v);
        return v > 2097151 ? 2097151 : v;
    endfunction

    function automatic pose_t make_pose(logic done, logic degen);
        pose_t p;
        p.px = cur_x[POS_W-1:0];
        p.py = cur_y[POS_W-1:0];
        p.hd = cur_hd[ANG_W-1:0];
        p.span = cur_span;
        p.done = done;
        p.degen = degen;
        return p;
    endfunction

    function automatic void queue_pose(pose_t p);
        pose_q.insert(pose_q.size(), p);
    endfunction

    task automatic locate_pose(output logic degen);
        longint dx, dy, sq, x, y, z, xs, ys;
        dx = longint'(lx) - longint'(rx);
        dy = longint'(ly) - longint'(ry);
        sq = dx * dx + dy * dy;
        cur_x = ((longint'(lx) + rx) << FRACTION_BITS) >> 1;
        cur_y = ((longint'(ly) + ry) << FRACTION_BITS) >> 1;
        degen = (sq == 0);
        if (degen) begin
            cur_hd = 0;
            cur_span = '0;
            radius = 0;
        end
        else begin
            cur_span = clip_span(isqrt(sq, FRACTION_BITS));
            radius = clip_span(isqrt(sq * 2, FRACTION_BITS - 1));
            x = (dy < 0 ? -dy : dy) * 65536;
            y = dx * 65536;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                xs = fl_shift(x, i);
                ys = fl_shift(y, i);
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_lut[i];
                end
                else begin
                    x -= ys; y += xs; z -= atan_lut[i];
                end
            end
            cur_hd = wrap_deg(-round_div(z, 512));
        end
    endtask

    function automatic logic try_move(longint mm);
        longint x, y, z, xs, ys, c, s, nx, ny, lo, pad;
        int h;
        logic flip;
        x = CORDIC_GAIN;
        y = 0;
        h = cur_hd;
        flip = 0;
        if (h > QUARTER_TURN) begin
            h -= HALF_TURN; flip = 1;
        end
        else if (h < -QUARTER_TURN) begin
            h += HALF_TURN; flip = 1;
        end
        z = longint'(h) * 512;
        for (int i = 0; i < STEPS; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
            else begin
                x += ys; y -= xs; z += atan_lut[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        nx = cur_x + round_div(mm * c * 256, longint'(MM_PER_PIXEL) << 30);
        ny = cur_y - round_div(mm * s * 256, longint'(MM_PER_PIXEL) << 30);
        pad = (longint'(pad_set) << FRACTION_BITS) / MM_PER_PIXEL;
        lo = pad + radius;
        if (nx > lo && nx < (longint'(ext_x) << FRACTION_BITS) - lo &&
            ny > lo && ny < (longint'(ext_y) << FRACTION_BITS) - lo) begin
            cur_x = nx;
            cur_y = ny;
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pose_t got, want;
        logic  degen, done;
        if (!rst_n) begin
            thr_green <= 200; thr_blue <= 200;
            ext_x <= 800; ext_y <= 600; pad_set <= 200;
            lx = 0; ly = 0; rx = 0; ry = 0;
            cur_x = 0; cur_y = 0; cur_hd = 0; cur_span = 0; radius = 0;
            pose_q.delete();
            fail_count <= 0;
            pose_count <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_GREEN:  thr_green <= cfg.data[7:0];
                    REG_BLUE:   thr_blue <= cfg.data[7:0];
                    REG_WIDTH:  ext_x <= cfg.data[12:0];
                    REG_HEIGHT: ext_y <= cfg.data[12:0];
                    REG_PAD:    pad_set <= cfg.data;
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                case (mode_t'(cmd.mode))
                    MODE_PIXEL: begin
                        if (cmd.pixel_word[23:16] >= thr_green) begin
                            lx = cmd.row_index; ly = cmd.column_index;
                        end
                        if (cmd.pixel_word[31:24] >= thr_blue) begin
                            rx = cmd.row_index; ry = cmd.column_index;
                        end
                        if (cmd.frame_end) begin
                            locate_pose(degen);
                            queue_pose(make_pose(0, degen));
                            lx = 0; ly = 0; rx = 0; ry = 0;
                        end
                    end
                    MODE_ROTATE: begin
                        cur_hd = wrap_deg(longint'(cur_hd) + cmd.angle_value);
                        queue_pose(make_pose(0, 0));
                    end
                    MODE_SET: begin
                        cur_hd = wrap_deg(cmd.angle_value);
                        queue_pose(make_pose(0, 0));
                    end
                    default: begin
                        done = try_move(cmd.distance_mm);
                        queue_pose(make_pose(done, 0));
                    end
                endcase
            end
            if (result.valid && result.ready) begin
                pose_count <= pose_count + 1;
                got.px = result.pose_x;
                got.py = result.pose_y;
                got.hd = result.heading;
                got.span = result.marker_span;
                got.done = result.move_done;
                got.degen = result.degenerate;
                if (pose_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer at %0t", $time);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = pose_q.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display({"mismatch at %0t: exp x=%0d y=%0d h=%0d span=%0d",
                                      " done=%0b deg=%0b got x=%0d y=%0d h=%0d span=%0d",
                                      " done=%0b deg=%0b"},
                                     $time, want.px, want.py, want.hd, want.span, want.done,
                                     want.degen, got.px, got.py, got.hd, got.span, got.done,
                                     got.degen);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = pose_q.size();
    end

endmodule

@@ tb/sv/marker_pose_tracker_test.sv @@
module marker_pose_tracker_test;
    import mpt_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count, pending, pose_count;
    int   idle_cycles;
    int   item_count;
    bit   hold_off;

    mpt_cmd_if cmd ();
    mpt_res_if result ();
    mpt_cfg_if cfg ();

    marker_pose_tracker uut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .result(result), .cfg(cfg));

    marker_pose_tracker_checker check (.clk(clk), .rst_n(rst_n), .cmd(cmd), .result(result),
        .cfg(cfg), .fail_count(fail_count), .pending(pending), .pose_count(pose_count));

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send(mode_t m, logic [31:0] pw, logic [11:0] r, logic [11:0] c,
                        logic fe, logic signed [15:0] ang, logic signed [15:0] mm);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 4) == 0)
            gap = 0;
        if (gap > 0) begin
            cmd.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1;
        cmd.mode <= m;
        cmd.pixel_word <= pw;
        cmd.row_index <= r;
        cmd.column_index <= c;
        cmd.frame_end <= fe;
        cmd.angle_value <= ang;
        cmd.distance_mm <= mm;
        do @(posedge clk); while (!cmd.ready);
        item_count++;
    endtask

    task automatic idle_cmd();
        cmd.valid <= 0;
    endtask

    // a short frame with random marker placement; pixels are forced green, blue or background, or left random
    task automatic send_frame(int npix);
        logic [31:0] pw;
        for (int i = 0; i < npix; i++) begin
            pw = $urandom();
            case ($urandom_range(0, 5))
                0: pw[23:16] = 8'hff;
                1: pw[31:24] = 8'hff;
                2: pw[31:16] = 16'h0000;
                default: ;
            endcase
            send(MODE_PIXEL, pw, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 i == npix - 1, 16'($urandom()), 16'($urandom()));
        end
    endtask

    task automatic random_cmd();
        case ($urandom_range(0, 9))
            0, 1: send(MODE_ROTATE, $urandom(), 12'($urandom()), 12'($urandom()),
                       1'($urandom()),
                       16'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000) - 1000),
                       16'($urandom()));
            2: send(MODE_SET, $urandom(), 12'($urandom()), 12'($urandom()), 1'($urandom()),
                    16'($urandom()), 16'($urandom()));
            3: send_frame($urandom_range(1, 6));
            default: send(MODE_MOVE, $urandom(), 12'($urandom()), 12'($urandom()),
                          1'($urandom()), 16'($urandom()),
                          16'($urandom_range(0, 3) == 0 ? $urandom()
                              : $urandom_range(0, 4000) - 2000));
        endcase
    endtask

    // result side: random stalls, plus one long hold-off
    initial begin
        result.ready = 0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                result.ready <= 0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            if ($urandom_range(0, 2) == 0) begin
                result.ready <= 0;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end
            result.ready <= 1;
            @(posedge clk);
        end
    end

    initial begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                stall = 0;
            else
                stall++;
            if (stall > 20000) begin
                $display("timeout: no transfer for %0d cycles", stall);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        cmd.valid = 0; cmd.mode = MODE_PIXEL; cmd.pixel_word = 0; cmd.row_index = 0;
        cmd.column_index = 0; cmd.frame_end = 0; cmd.angle_value = 0; cmd.distance_mm = 0;
        cfg.valid = 0; cfg.index = REG_GREEN; cfg.data = 0;
        hold_off = 0;
        item_count = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: default config
        send(MODE_PIXEL, 32'h00c8_0000, 12'd100, 12'd300, 0, 0, 0);
        send(MODE_PIXEL, 32'hc800_0000, 12'd300, 12'd300, 1, 0, 0);
        send(MODE_MOVE, 0, 0, 0, 0, 0, 16'sd200);
        send(MODE_MOVE, 0, 0, 0, 0, 0, -16'sd32768);
        send(MODE_ROTATE, 0, 0, 0, 0, 16'sd23039, 0);
        send(MODE_ROTATE, 0, 0, 0, 0, -16'sd32768, 0);
        send(MODE_SET, 0, 0, 0, 0, -16'sd23040, 0);
        send(MODE_SET, 0, 0, 0, 0, 16'sd32767, 0);
        send(MODE_SET, 0, 0, 0, 0, 16'sd11520, 0);
        send(MODE_MOVE, 0, 0, 0, 0, 0, 16'sd32767);
        // equal markers
        send(MODE_PIXEL, 32'hffff_ffff, 12'd4095, 12'd4095, 1, 0, 0);
        send(MODE_PIXEL, 32'h0000_0000, 12'd0, 12'd0, 1, 0, 0);
        // widest span
        send(MODE_PIXEL, 32'h00ff_0000, 12'd0, 12'd0, 0, 0, 0);
        send(MODE_PIXEL, 32'hff00_ffff, 12'd4095, 12'd4095, 1, 0, 0);
        send(MODE_PIXEL, 32'h00ff_0000, 12'd400, 12'd100, 0, 0, 0);
        send(MODE_PIXEL, 32'hff00_0000, 12'd400, 12'd500, 1, 0, 0);
        send(MODE_MOVE, 0, 0, 0, 0, 0, 16'sd100);
        idle_cmd();
        wait_drained();

        // extremes of the config, in two opposite sets
        write_reg(REG_GREEN, 16'd0);
        write_reg(REG_BLUE, 16'd255);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd4096);
        write_reg(REG_PAD, 16'hffff);
        for (int i = 0; i < 40; i++)
            random_cmd();
        idle_cmd();
        wait_drained();

        write_reg(REG_GREEN, 16'd255);
        write_reg(REG_BLUE, 16'd0);
        write_reg(REG_WIDTH, 16'd4096);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_PAD, 16'd0);
        for (int i = 0; i < 40; i++)
            random_cmd();
        idle_cmd();
        wait_drained();

        // sender pauses for the pipe to empty, then receiver holds off while we push
        write_reg(REG_GREEN, 16'd128);
        write_reg(REG_BLUE, 16'd128);
        write_reg(REG_WIDTH, 16'd4096);
        write_reg(REG_HEIGHT, 16'd4096);
        write_reg(REG_PAD, 16'd20);
        send_frame(2);
        idle_cmd();
        wait_drained();
        hold_off = 1;
        for (int i = 0; i < 30; i++)
            send(MODE_ROTATE, 0, 0, 0, 0, 16'($urandom()), 0);
        for (int i = 0; i < 200; i++)
            random_cmd();
        idle_cmd();
        wait_drained();

        write_reg(REG_WIDTH, 16'd800);
        write_reg(REG_HEIGHT, 16'd600);
        write_reg(REG_PAD, 16'd200);
        write_reg(REG_GREEN, 16'd200);
        write_reg(REG_BLUE, 16'd200);
        for (int i = 0; i < 150; i++)
            random_cmd();
        idle_cmd();
        wait_drained();

        $display("covered %0d command transfers and %0d pose results over four config sets",
                 item_count, pose_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
